/* rtl/core/sfrsc_pkg.sv */
// ----------------------------------------------------------------------------
// sfrsc_pkg
// Shared types and constants for the sync frame receiver with sum check.
// ----------------------------------------------------------------------------
package sfrsc_pkg;

    localparam int FRAME_LEN_DEF = 20;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 5;
    localparam int CFG_IDX_W = 2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_THIRD  = 2'd2;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_SECOND  = 2'd1,
        PH_THIRD   = 2'd2,
        PH_COLLECT = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        DR_IDLE = 2'd0,
        DR_SHOW = 2'd1,
        DR_ERR  = 2'd2
    } drain_t;

    // one finished frame handed from the front to the back
    typedef struct packed {
        logic slot;   // frame buffer half that holds the frame
        logic bad;    // checksum mismatch
    } job_t;

endpackage

/* rtl/core/sfrsc_front.sv */
// ----------------------------------------------------------------------------
// sfrsc_front
// Sync hunt, frame collection into the buffer, and checksum classification.
// ----------------------------------------------------------------------------
module sfrsc_front
    import sfrsc_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF,
    parameter int IDX_W     = $clog2(FRAME_LEN)
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 acc,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 wr_en,
    output logic                 wr_slot,
    output logic [IDX_W-1:0]     wr_idx,
    output logic [BYTE_W-1:0]    wr_data,
    output logic                 push,
    output job_t                 push_job
);

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);
    localparam logic [IDX_W-1:0] SUM_END  = IDX_W'(FRAME_LEN - 2);

    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic [BYTE_W-1:0] sync_third_reg;

    phase_t            phase_reg, phase_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;
    logic              slot_reg, slot_next;

    logic match;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= '0;
            sync_second_reg <= '0;
            sync_third_reg  <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                CFG_SYNC_THIRD:  sync_third_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (phase_reg)
            PH_HUNT:    match = (rx_byte == sync_first_reg);
            PH_SECOND:  match = (rx_byte == sync_second_reg);
            PH_THIRD:   match = (rx_byte == sync_third_reg);
            PH_COLLECT: match = 1'b1;
        endcase
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        if (acc)
        begin
            unique case (phase_reg)
                PH_HUNT:    if (match) phase_next = PH_SECOND;
                PH_SECOND:  phase_next = match ? PH_THIRD : PH_HUNT;
                PH_THIRD:   phase_next = match ? PH_COLLECT : PH_HUNT;
                PH_COLLECT: if (cnt_reg == LAST_IDX) phase_next = PH_HUNT;
            endcase
        end
    end

    // outputs and datapath
    always_comb
    begin
        wr_en         = acc && match;
        wr_slot       = slot_reg;
        wr_idx        = (phase_reg == PH_HUNT) ? '0 : cnt_reg;
        wr_data       = rx_byte;
        push          = 1'b0;
        push_job.slot = slot_reg;
        push_job.bad  = (sum_reg != rx_byte);
        cnt_next      = cnt_reg;
        sum_next      = sum_reg;
        slot_next     = slot_reg;
        if (acc)
        begin
            unique case (phase_reg)
                PH_HUNT:
                begin
                    if (match)
                    begin
                        cnt_next = IDX_W'(1);
                        sum_next = rx_byte;
                    end
                end
                PH_SECOND, PH_THIRD:
                begin
                    if (match)
                    begin
                        cnt_next = cnt_reg + IDX_W'(1);
                        sum_next = sum_reg + rx_byte;
                    end
                    else
                    begin
                        cnt_next = '0;
                        sum_next = '0;
                    end
                end
                PH_COLLECT:
                begin
                    if (cnt_reg == LAST_IDX)
                    begin
                        push      = 1'b1;
                        slot_next = ~slot_reg;
                        cnt_next  = '0;
                        sum_next  = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + IDX_W'(1);
                        if (cnt_reg < SUM_END)
                            sum_next = sum_reg + rx_byte;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_HUNT;
            cnt_reg   <= '0;
            sum_reg   <= '0;
            slot_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            sum_reg   <= sum_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

/* rtl/core/sfrsc_queue.sv */
// ----------------------------------------------------------------------------
// sfrsc_queue
// Two-entry queue of finished frame jobs between front and back.
// ----------------------------------------------------------------------------
module sfrsc_queue
    import sfrsc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    input  job_t       push_job,
    input  logic       pop,
    output logic       head_valid,
    output job_t       head,
    output logic [1:0] count
);

    job_t       entry_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg, count_next;

    assign head_valid = (count_reg != 2'd0);
    assign head       = entry_reg[rd_ptr_reg];
    assign count      = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

endmodule

/* rtl/core/sfrsc_back.sv */
// ----------------------------------------------------------------------------
// sfrsc_back
// Frame buffer and drain sequencer that turns each job into results.
// ----------------------------------------------------------------------------
module sfrsc_back
    import sfrsc_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF,
    parameter int IDX_W     = $clog2(FRAME_LEN)
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_en,
    input  logic               wr_slot,
    input  logic [IDX_W-1:0]   wr_idx,
    input  logic [BYTE_W-1:0]  wr_data,
    input  logic               head_valid,
    input  job_t               head,
    output logic               pop,
    output logic               busy,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [BYTE_W-1:0]  frame_byte,
    output logic [INDEX_W-1:0] byte_index,
    output logic               last,
    output logic               status
);

    localparam int               DEPTH    = 2 ** (IDX_W + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LEN - 1);

    logic [BYTE_W-1:0] mem [DEPTH];
    logic [BYTE_W-1:0] rdata_reg;

    drain_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic             slot_reg, slot_next;

    logic             rd_en;
    logic             rd_slot;
    logic [IDX_W-1:0] rd_idx;
    logic             out_acc;
    logic [31:0]      idx_wide;

    assign out_acc = out_valid && !out_stall;

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[{wr_slot, wr_idx}] <= wr_data;
        if (rd_en)
            rdata_reg <= mem[{rd_slot, rd_idx}];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DR_IDLE:
                if (head_valid)
                    state_next = head.bad ? DR_ERR : DR_SHOW;
            DR_SHOW:
                if (out_acc && idx_reg == LAST_IDX)
                    state_next = DR_IDLE;
            DR_ERR:
                if (out_acc)
                    state_next = DR_IDLE;
            default:
                state_next = DR_IDLE;
        endcase
    end

    // outputs and read control
    always_comb
    begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        rd_slot   = slot_reg;
        rd_idx    = idx_reg + IDX_W'(1);
        idx_next  = idx_reg;
        slot_next = slot_reg;
        unique case (state_reg)
            DR_IDLE:
            begin
                pop       = head_valid;
                rd_slot   = head.slot;
                rd_idx    = '0;
                rd_en     = head_valid && !head.bad;
                idx_next  = '0;
                slot_next = head.slot;
            end
            DR_SHOW:
            begin
                if (out_acc && idx_reg != LAST_IDX)
                begin
                    rd_en    = 1'b1;
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            default: ;
        endcase
    end

    assign busy       = (state_reg != DR_IDLE);
    assign out_valid  = (state_reg == DR_SHOW) || (state_reg == DR_ERR);
    assign idx_wide   = 32'(idx_reg);
    assign frame_byte = (state_reg == DR_SHOW) ? rdata_reg : '0;
    assign byte_index = (state_reg == DR_SHOW) ? idx_wide[INDEX_W-1:0] : '0;
    assign last       = (state_reg == DR_ERR) || (idx_reg == LAST_IDX);
    assign status     = (state_reg == DR_ERR);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DR_IDLE;
            idx_reg   <= '0;
            slot_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            slot_reg  <= slot_next;
        end
    end

endmodule

/* rtl/core/sync_frame_receiver_sum_check.sv */
// ----------------------------------------------------------------------------
// sync_frame_receiver_sum_check
// Hunts a three-byte sync header, collects fixed-length frames, checks the
// additive checksum and replays good frames byte by byte.
// ----------------------------------------------------------------------------
//
//  channel   | direction | handshake              | payload
//  ----------+-----------+------------------------+---------------------------
//  input     | in        | in_valid / in_stall    | rx_byte
//  output    | out       | out_valid / out_stall  | frame_byte, byte_index,
//            |           |                        | last, status
//  config    | in        | cfg_we                 | cfg_index, cfg_data
//
// A received byte is accepted every cycle as long as fewer than two finished
// frames are still held; the frame buffer has two halves, so a third frame
// waits (in_stall) until the back end releases one half.
// A good frame drains at one result per cycle, the first in the cycle after
// its buffer read starts; a bad frame gives its single error result in the
// cycle after the job reaches the back end. Output stalls hold the current
// transaction. Reset clears the sync registers, the hunt state, counters and
// the job queue; the frame buffer is not cleared and needs no clearing pass.
// ----------------------------------------------------------------------------
module sync_frame_receiver_sum_check
    import sfrsc_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BYTE_W-1:0]    frame_byte,
    output logic [INDEX_W-1:0]   byte_index,
    output logic                 last,
    output logic                 status
);

    localparam int IDX_W = $clog2(FRAME_LEN);

    logic              in_acc;
    logic              wr_en;
    logic              wr_slot;
    logic [IDX_W-1:0]  wr_idx;
    logic [BYTE_W-1:0] wr_data;
    logic              push;
    job_t              push_job;
    logic              pop;
    logic              head_valid;
    job_t              head;
    logic [1:0]        q_count;
    logic              busy;
    logic [2:0]        held;

    // Count buffer halves owned by the back end: queued jobs plus the one
    // being drained. Hold the input once both halves are taken.
    assign held     = {1'b0, q_count} + {2'b00, busy};
    assign in_stall = (held >= 3'd2);
    assign in_acc   = in_valid && !in_stall;

    sfrsc_front #(
        .FRAME_LEN (FRAME_LEN),
        .IDX_W     (IDX_W)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .acc       (in_acc),
        .rx_byte   (rx_byte),
        .wr_en     (wr_en),
        .wr_slot   (wr_slot),
        .wr_idx    (wr_idx),
        .wr_data   (wr_data),
        .push      (push),
        .push_job  (push_job)
    );

    sfrsc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head),
        .count      (q_count)
    );

    sfrsc_back #(
        .FRAME_LEN (FRAME_LEN),
        .IDX_W     (IDX_W)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_slot    (wr_slot),
        .wr_idx     (wr_idx),
        .wr_data    (wr_data),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .busy       (busy),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .last       (last),
        .status     (status)
    );

endmodule

/* verif/sfrsc_frame_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sfrsc_frame_checker
// Watches the byte, result and register ports of the sync frame receiver,
// rebuilds the frames it should find and checks every replayed byte and every
// checksum error against them, oldest first.
// ----------------------------------------------------------------------------
module sfrsc_frame_checker
    import sfrsc_pkg::*;
#(
    parameter int FRAME_LEN = FRAME_LEN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_stall,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 out_valid,
    input  logic                 out_stall,
    input  logic [BYTE_W-1:0]    frame_byte,
    input  logic [INDEX_W-1:0]   byte_index,
    input  logic                 last,
    input  logic                 status,
    output int                   mismatches,
    output int                   pending,
    output int                   results_seen,
    output int                   good_frames,
    output int                   bad_frames
);

    typedef struct packed {
        logic [BYTE_W-1:0]  data;
        logic [INDEX_W-1:0] index;
        logic               last;
        logic               status;
    } frame_result_t;

    frame_result_t      frame_results_due[$];

    logic [BYTE_W-1:0]  sync_val [3];
    phase_t             hunt_phase;
    int                 held;
    logic [BYTE_W-1:0]  frame_buf [FRAME_LEN];
    logic [BYTE_W-1:0]  body_sum;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("%0t ns sfrsc_frame_checker: %s", $time, what);
    endtask

    task automatic drop_to_hunt();
        hunt_phase = PH_HUNT;
        held       = 0;
        body_sum   = '0;
    endtask

    task automatic hold_byte(input logic [BYTE_W-1:0] b);
        if (held < FRAME_LEN) begin
            frame_buf[held] = b;
            if (held < FRAME_LEN - 2)
                body_sum = body_sum + b;
            held++;
        end
    endtask

    // Advance the frame search by one received byte and queue what it yields.
    task automatic predict_byte(input logic [BYTE_W-1:0] b);
        frame_result_t r;
        case (hunt_phase)
            PH_HUNT:
            begin
                if (b == sync_val[0])
                begin
                    drop_to_hunt();
                    hold_byte(b);
                    hunt_phase = PH_SECOND;
                end
            end
            PH_SECOND:
            begin
                if (b == sync_val[1])
                begin
                    hold_byte(b);
                    hunt_phase = PH_THIRD;
                end
                else
                    drop_to_hunt();
            end
            PH_THIRD:
            begin
                if (b == sync_val[2])
                begin
                    hold_byte(b);
                    hunt_phase = PH_COLLECT;
                end
                else
                    drop_to_hunt();
            end
            default:
            begin
                hold_byte(b);
                if (held == FRAME_LEN)
                begin
                    if (body_sum == frame_buf[FRAME_LEN-1])
                    begin
                        for (int k = 0; k < FRAME_LEN; k++)
                        begin
                            r.data   = frame_buf[k];
                            r.index  = k[INDEX_W-1:0];
                            r.last   = (k == FRAME_LEN - 1);
                            r.status = 1'b0;
                            frame_results_due.push_back(r);
                        end
                        good_frames++;
                    end
                    else
                    begin
                        r.data   = '0;
                        r.index  = '0;
                        r.last   = 1'b1;
                        r.status = 1'b1;
                        frame_results_due.push_back(r);
                        bad_frames++;
                    end
                    drop_to_hunt();
                end
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_result_t want;
        if (!rst_n)
        begin
            foreach (sync_val[i])
                sync_val[i] = '0;
            drop_to_hunt();
            frame_results_due.delete();
            mismatches   = 0;
            results_seen = 0;
            good_frames  = 0;
            bad_frames   = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYNC_FIRST:  sync_val[0] = cfg_data;
                    CFG_SYNC_SECOND: sync_val[1] = cfg_data;
                    CFG_SYNC_THIRD:  sync_val[2] = cfg_data;
                    default: ;
                endcase
            end

            if (in_valid && !in_stall)
                predict_byte(rx_byte);

            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (frame_results_due.size() == 0)
                    report_mismatch($sformatf(
                        "result with none due: byte %02h index %0d last %b status %b",
                        frame_byte, byte_index, last, status));
                else
                begin
                    want = frame_results_due.pop_front();
                    if (frame_byte !== want.data)
                        report_mismatch($sformatf("frame_byte %02h, want %02h (index %0d)",
                            frame_byte, want.data, want.index));
                    if (byte_index !== want.index)
                        report_mismatch($sformatf("byte_index %0d, want %0d",
                            byte_index, want.index));
                    if (last !== want.last)
                        report_mismatch($sformatf("last %b, want %b (index %0d)",
                            last, want.last, want.index));
                    if (status !== want.status)
                        report_mismatch($sformatf("status %b, want %b (index %0d)",
                            status, want.status, want.index));
                end
            end
        end
        pending = frame_results_due.size();
    end

endmodule

/* verif/sync_frame_receiver_sum_check_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sync_frame_receiver_sum_check_test
// Feeds the sync frame receiver with good frames, frames with a wrong sum,
// broken headers and line noise under several sync settings, with random
// gaps on the byte side and random stalls on the result side; the frame
// checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module sync_frame_receiver_sum_check_test;

    import sfrsc_pkg::*;

    localparam int FRAME_LEN    = FRAME_LEN_DEF;
    localparam int HOLD_CYCLES  = 400;   // long receiver hold-off
    localparam int SETTLE       = 10;    // cycles to let the block go quiet
    localparam int PHASE_BYTES  = 24;    // minimum bytes sent per random phase
    localparam int DRAIN_LIMIT  = 50000;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_stall;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_stall;
    logic [BYTE_W-1:0]    frame_byte;
    logic [INDEX_W-1:0]   byte_index;
    logic                 last;
    logic                 status;

    int mismatches;
    int pending;
    int results_seen;
    int good_frames;
    int bad_frames;

    // stimulus knobs, flipped by the main sequence
    bit idle_on;
    bit stall_on;
    bit hold_req;
    int bytes_sent;
    int settings_used;
    logic [BYTE_W-1:0] sync_cur [3];

    always #5 clk = ~clk;

    sync_frame_receiver_sum_check #(
        .FRAME_LEN (FRAME_LEN)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .frame_byte (frame_byte),
        .byte_index (byte_index),
        .last       (last),
        .status     (status)
    );

    sfrsc_frame_checker #(
        .FRAME_LEN (FRAME_LEN)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .frame_byte   (frame_byte),
        .byte_index   (byte_index),
        .last         (last),
        .status       (status),
        .mismatches   (mismatches),
        .pending      (pending),
        .results_seen (results_seen),
        .good_frames  (good_frames),
        .bad_frames   (bad_frames)
    );

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(0, 2);
        else if (r < 92)
            return $urandom_range(1, 5);
        else
            return $urandom_range(10, 40);
    endfunction

    // Offer one byte and hold it until the block takes it. Valid stays high
    // across back-to-back transactions; it only drops when a gap is inserted.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= b;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        bytes_sent++;
    endtask

    // Drop valid and wait until every predicted result has come out, then let
    // the block settle before touching its registers.
    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic set_syncs(input logic [BYTE_W-1:0] a, b, c);
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data  <= a;
        @(posedge clk);
        cfg_index <= CFG_SYNC_SECOND;
        cfg_data  <= b;
        @(posedge clk);
        cfg_index <= CFG_SYNC_THIRD;
        cfg_data  <= c;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sync_cur[0] = a;
        sync_cur[1] = b;
        sync_cur[2] = c;
        settings_used++;
    endtask

    // One full frame that starts with the current header. The body leans toward the
    // byte extremes; the spare byte before the sum is random on purpose since
    // the block must ignore it.
    task automatic send_frame(input bit good);
        logic [BYTE_W-1:0] f [FRAME_LEN];
        logic [BYTE_W-1:0] sum;
        int                r;
        sum = '0;
        for (int i = 0; i < FRAME_LEN - 2; i++)
        begin
            if (i < 3)
                f[i] = sync_cur[i];
            else
            begin
                r = $urandom_range(0, 9);
                f[i] = (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : BYTE_W'($urandom);
            end
            sum = sum + f[i];
        end
        f[FRAME_LEN-2] = BYTE_W'($urandom);
        f[FRAME_LEN-1] = good ? sum : BYTE_W'(sum + $urandom_range(1, 255));
        for (int i = 0; i < FRAME_LEN; i++)
            send_byte(f[i]);
    endtask

    // Noise, headers that break on the second or third byte, or a frame cut
    // short (its tail is taken from whatever follows).
    task automatic send_broken();
        logic [BYTE_W-1:0] b;
        int                n;
        case ($urandom_range(0, 3))
            0:
            begin
                n = $urandom_range(1, 4);
                repeat (n) send_byte(BYTE_W'($urandom));
            end
            1:
            begin
                // the bad second byte is often the first sync value itself,
                // which must not restart the header
                b = $urandom_range(0, 1) ? sync_cur[0] : BYTE_W'($urandom);
                if (b == sync_cur[1])
                    b = ~sync_cur[1];
                send_byte(sync_cur[0]);
                send_byte(b);
            end
            2:
            begin
                b = $urandom_range(0, 1) ? sync_cur[0] : BYTE_W'($urandom);
                if (b == sync_cur[2])
                    b = ~sync_cur[2];
                send_byte(sync_cur[0]);
                send_byte(sync_cur[1]);
                send_byte(b);
            end
            default:
            begin
                n = $urandom_range(1, FRAME_LEN - 4);
                send_byte(sync_cur[0]);
                send_byte(sync_cur[1]);
                send_byte(sync_cur[2]);
                repeat (n) send_byte(BYTE_W'($urandom));
            end
        endcase
    endtask

    // Mostly well-formed frames, some with a wrong sum, the rest broken.
    task automatic random_phase(input bit with_hold);
        int start;
        int r;
        start = bytes_sent;
        if (with_hold)
        begin
            // stall the result side for a long stretch while frames keep
            // coming back to back, so the two-frame buffer fills up
            hold_req = 1'b1;
            idle_on  = 1'b0;
            repeat (3) send_frame(1'b1);
        end
        while (bytes_sent - start < PHASE_BYTES)
        begin
            idle_on  = ($urandom_range(0, 3) != 0);
            stall_on = ($urandom_range(0, 3) != 0);
            r = $urandom_range(0, 99);
            if (r < 65)
                send_frame(1'b1);
            else if (r < 80)
                send_frame(1'b0);
            else
                send_broken();
        end
    endtask

    // Result side: runs of ready cycles broken by stalls, plus the one long
    // hold-off on request. The hold is counted here, not by the sender.
    initial
    begin
        out_stall = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
            begin : ready_run
                int gap;
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
                gap = stall_on ? pick_gap() : 0;
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap) @(posedge clk);
                end
            end
        end
    end

    initial
    begin : stimulus
        int waited;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_SYNC_FIRST;
        cfg_data  = '0;
        in_valid  = 1'b0;
        rx_byte   = '0;
        idle_on   = 1'b0;
        stall_on  = 1'b0;
        hold_req  = 1'b0;
        bytes_sent    = 0;
        settings_used = 1;
        foreach (sync_cur[i])
            sync_cur[i] = '0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: reset sync values (all zero). Noise is dropped, a header
        // broken on the second or third byte yields nothing, then one frame.
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'h01);
        send_byte(8'h00);
        send_byte(8'h00);
        send_byte(8'h80);
        send_frame(1'b1);

        // Directed: distinct sync values; a repeated first sync byte in the
        // second slot drops the header, then a frame with a wrong sum.
        set_syncs(8'hA5, 8'h5A, 8'h3C);
        send_byte(8'hA5);
        send_byte(8'hA5);
        send_frame(1'b0);

        // Random: a spread of sync settings, the byte extremes among them.
        idle_on  = 1'b1;
        stall_on = 1'b1;
        random_phase(1'b0);
        set_syncs(8'hFF, 8'hFF, 8'hFF);
        random_phase(1'b1);
        set_syncs(8'h00, 8'hFF, 8'h80);
        random_phase(1'b0);
        set_syncs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        random_phase(1'b0);
        set_syncs(BYTE_W'($urandom), BYTE_W'($urandom), BYTE_W'($urandom));
        random_phase(1'b0);

        // Drain: wait for the last results, with a limit, then let it settle.
        in_valid <= 1'b0;
        @(posedge clk);
        waited = 0;
        while (pending != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (4 * SETTLE) @(posedge clk);

        $display("Covered %0d received bytes under %0d sync settings, with a %0d-cycle hold-off.",
            bytes_sent, settings_used, HOLD_CYCLES);
        $display("Checked %0d results: %0d good frames replayed, %0d checksum errors, %0d left.",
            results_seen, good_frames, bad_frames, pending);
        if (mismatches == 0 && pending == 0)
            $display("sync_frame_receiver_sum_check_test: PASS");
        else
            $display("sync_frame_receiver_sum_check_test: FAIL");
        $finish;
    end

    // Watchdog: a correct run takes well under a tenth of this.
    initial
    begin
        #(5_000_000);
        $display("Timed out with %0d results still due.", pending);
        $display("sync_frame_receiver_sum_check_test: FAIL");
        $finish;
    end

endmodule
